FILE: hw/rtl/cslbp_pkg.sv
// ----------------------------------------------------------------------------
// CS-LBP package
// Shared types and constants for the radius-2, eight-point CS-LBP stream block.
// ----------------------------------------------------------------------------
package cslbp_pkg;

    localparam int CODE_W = 4;
    localparam int SUM_W  = 20;
    localparam int LINE_W = 32;   // four stored rows of one column
    localparam int COLM_W = 40;   // one window column, five rows

    // Bilinear weights in Q0.12; A + 2B + C is exactly 4096.
    localparam logic [10:0] WGT_A = 11'd703;
    localparam logic [10:0] WGT_B = 11'd994;
    localparam logic [10:0] WGT_C = 11'd1405;

    localparam logic [15:0] MIN_DIM  = 16'd5;
    localparam logic [15:0] MIN_EDGE = 16'd4;

    localparam int FIFO_DEPTH = 8;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 8'd1;

    // Control that travels with each pixel down the pipeline.
    typedef struct packed {
        logic valid;
        logic emit;
        logic last;
    } tag_t;

    typedef struct packed {
        logic              last;
        logic [CODE_W-1:0] code;
    } result_t;

endpackage

FILE: hw/rtl/cslbp_ram.sv
// ----------------------------------------------------------------------------
// CS-LBP generic RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module cslbp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/cslbp_window.sv
// ----------------------------------------------------------------------------
// CS-LBP window and code unit
// Holds the 5x5 window, forms the interpolated diagonal sums and the code.
// ----------------------------------------------------------------------------
module cslbp_window (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cslbp_pkg::tag_t                in_tag,
    input  logic [cslbp_pkg::COLM_W-1:0]   in_column,
    output logic                           push,
    output cslbp_pkg::result_t             result
);

    localparam int SW = cslbp_pkg::SUM_W;

    // Column 4 is the newest; byte r of a column is window row r.
    logic [cslbp_pkg::COLM_W-1:0] win_reg [5];
    cslbp_pkg::tag_t              s2_tag_reg;
    cslbp_pkg::tag_t              s3_tag_reg;
    logic [SW-1:0]                ne_reg, sw_reg, nw_reg, se_reg;
    logic [SW-1:0]                ne_next, sw_next, nw_next, se_next;
    logic                         ew_reg, ns_reg;
    logic [7:0]                   pv [5][5];

    always_comb
    begin
        for (int r = 0; r < 5; r++)
        begin
            for (int c = 0; c < 5; c++)
            begin
                pv[r][c] = win_reg[c][8*r +: 8];
            end
        end
    end

    always_comb
    begin
        ne_next = SW'(cslbp_pkg::WGT_B) * SW'(pv[0][3]) + SW'(cslbp_pkg::WGT_A) * SW'(pv[0][4])
                + SW'(cslbp_pkg::WGT_C) * SW'(pv[1][3]) + SW'(cslbp_pkg::WGT_B) * SW'(pv[1][4]);
        sw_next = SW'(cslbp_pkg::WGT_B) * SW'(pv[3][0]) + SW'(cslbp_pkg::WGT_C) * SW'(pv[3][1])
                + SW'(cslbp_pkg::WGT_A) * SW'(pv[4][0]) + SW'(cslbp_pkg::WGT_B) * SW'(pv[4][1]);
        nw_next = SW'(cslbp_pkg::WGT_A) * SW'(pv[0][0]) + SW'(cslbp_pkg::WGT_B) * SW'(pv[0][1])
                + SW'(cslbp_pkg::WGT_B) * SW'(pv[1][0]) + SW'(cslbp_pkg::WGT_C) * SW'(pv[1][1]);
        se_next = SW'(cslbp_pkg::WGT_C) * SW'(pv[3][3]) + SW'(cslbp_pkg::WGT_B) * SW'(pv[3][4])
                + SW'(cslbp_pkg::WGT_B) * SW'(pv[4][3]) + SW'(cslbp_pkg::WGT_A) * SW'(pv[4][4]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
        end
        else
        begin
            s2_tag_reg <= in_tag;
            s3_tag_reg <= s2_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_tag.valid)
        begin
            for (int c = 0; c < 4; c++)
            begin
                win_reg[c] <= win_reg[c+1];
            end
            win_reg[4] <= in_column;
        end
        ne_reg <= ne_next;
        sw_reg <= sw_next;
        nw_reg <= nw_next;
        se_reg <= se_next;
        ew_reg <= (pv[2][4] >= pv[2][0]);
        ns_reg <= (pv[0][2] >= pv[4][2]);
    end

    assign push        = s3_tag_reg.valid && s3_tag_reg.emit;
    assign result.last = s3_tag_reg.last;
    assign result.code = {nw_reg >= se_reg, ns_reg, ne_reg >= sw_reg, ew_reg};

endmodule

FILE: hw/rtl/cslbp_fifo.sv
// ----------------------------------------------------------------------------
// CS-LBP output buffer
// Small register FIFO that holds finished codes until the sink takes them.
// ----------------------------------------------------------------------------
module cslbp_fifo #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_pop;

    assign valid  = (count_reg != '0);
    assign do_pop = pop && valid;
    assign data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/center_symmetric_lbp_r2_8pt.sv
// ----------------------------------------------------------------------------
// Center-symmetric LBP, radius 2, eight points
// Streaming CS-LBP coder with a line-store RAM, a 5x5 window and an output FIFO.
// ----------------------------------------------------------------------------
// Grayscale pixels enter in raster order, one word per clock, and the block
// returns one 4-bit CS-LBP code for every centre that lies two or more pixels
// inside the image, with tlast on the last code of the frame. After reset the
// line-store RAM is swept to zero, during which s_tready stays low;
// configuration writes are taken at all times. From then on the block accepts
// one pixel per clock: the line-store RAM is read at acceptance and written
// back the following cycle, and a code reaches the output buffer through the
// p1, s2 and s3 tag registers. The 8-word output buffer lets the input keep
// running while the sink stalls; s_tready falls only once eight codes are in
// flight or waiting.
module center_symmetric_lbp_r2_8pt #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    // Pixel input. tdata: pixel[7:0].
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // Code output. tdata: code[3:0], zero[7:4]. tlast: frame_last.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    // Configuration writes: index 0 is line_width, index 1 is frame_height.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int          AW     = $clog2(MAX_WIDTH);
    localparam int          OCC_W  = $clog2(cslbp_pkg::FIFO_DEPTH + 1);
    localparam logic [15:0] MAXW16 = 16'(MAX_WIDTH);

    // Configuration registers.
    logic [10:0] line_width_reg;
    logic [15:0] frame_height_reg;

    // Position of the next pixel in the frame.
    logic [AW-1:0] column_count_reg, column_count_next;
    logic [15:0]   row_count_reg, row_count_next;

    // Clearing sweep over the line store after reset.
    logic          clear_reg;
    logic [AW-1:0] clr_addr_reg;

    // Codes accepted but not yet delivered; this bounds the output buffer.
    logic [OCC_W-1:0] occ_reg, occ_next;

    // Stage after acceptance: the RAM read data is valid alongside these.
    cslbp_pkg::tag_t            p1_tag_reg, p1_tag_next;
    logic [7:0]                 p1_pix_reg;
    logic [AW-1:0]              p1_col_reg;

    logic [15:0]                eff_w, eff_h, lw16, col16;
    logic                       accept, eol, eof, emit;
    logic                       ram_wr_en;
    logic [AW-1:0]              ram_wr_addr;
    logic [cslbp_pkg::LINE_W-1:0] ram_wr_data, ram_rd_data;
    logic                       push;
    cslbp_pkg::result_t         result, out_word;
    logic                       out_pop;

    assign cfg_ready = 1'b1;
    assign s_tready  = !clear_reg && (occ_reg < OCC_W'(cslbp_pkg::FIFO_DEPTH));
    assign accept    = s_tvalid && s_tready;

    // The effective width is clamped to 5..MAX_WIDTH, the height raised to 5.
    always_comb
    begin
        lw16  = 16'(line_width_reg);
        col16 = 16'(column_count_reg);
        if (lw16 < cslbp_pkg::MIN_DIM)
        begin
            eff_w = cslbp_pkg::MIN_DIM;
        end
        else if (lw16 > MAXW16)
        begin
            eff_w = MAXW16;
        end
        else
        begin
            eff_w = lw16;
        end
        eff_h = (frame_height_reg < cslbp_pkg::MIN_DIM) ? cslbp_pkg::MIN_DIM : frame_height_reg;
        eol   = col16 >= (eff_w - 16'd1);
        eof   = eol && (row_count_reg >= (eff_h - 16'd1));
        emit  = (row_count_reg >= cslbp_pkg::MIN_EDGE) && (col16 >= cslbp_pkg::MIN_EDGE);
    end

    always_comb
    begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (accept)
        begin
            if (eol)
            begin
                column_count_next = '0;
                row_count_next    = eof ? 16'd0 : row_count_reg + 16'd1;
            end
            else
            begin
                column_count_next = column_count_reg + AW'(1);
            end
        end
        p1_tag_next.valid = accept;
        p1_tag_next.emit  = emit;
        p1_tag_next.last  = eof;
        occ_next = occ_reg + OCC_W'(accept && emit) - OCC_W'(out_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= 11'd640;
            frame_height_reg <= 16'd480;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            clear_reg        <= 1'b1;
            clr_addr_reg     <= '0;
            occ_reg          <= '0;
            p1_tag_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    cslbp_pkg::CFG_LINE_WIDTH:   line_width_reg   <= cfg_data[10:0];
                    cslbp_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                    default:                     ;
                endcase
            end
            if (clear_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(MAX_WIDTH - 1))
                begin
                    clear_reg <= 1'b0;
                end
            end
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            occ_reg          <= occ_next;
            p1_tag_reg       <= p1_tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_pix_reg <= s_tdata;
            p1_col_reg <= column_count_reg;
        end
    end

    // Read at acceptance, write back in the following cycle. The same column comes
    // round again no sooner than five pixels on, so the write always lands
    // before the next read of that entry and no forwarding path is needed.
    // The stored word drops its oldest row and takes the new pixel on top.
    assign ram_wr_en   = clear_reg || p1_tag_reg.valid;
    assign ram_wr_addr = clear_reg ? clr_addr_reg : p1_col_reg;
    assign ram_wr_data = clear_reg ? '0 : {p1_pix_reg, ram_rd_data[31:8]};

    cslbp_ram #(
        .WIDTH (cslbp_pkg::LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (column_count_reg),
        .rd_data (ram_rd_data)
    );

    // The new window column is the four stored rows with the pixel below them.
    cslbp_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tag    (p1_tag_reg),
        .in_column ({p1_pix_reg, ram_rd_data}),
        .push      (push),
        .result    (result)
    );

    assign out_pop = m_tvalid && m_tready;

    cslbp_fifo #(
        .WIDTH ($bits(cslbp_pkg::result_t)),
        .DEPTH (cslbp_pkg::FIFO_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (result),
        .pop       (m_tready),
        .valid     (m_tvalid),
        .data      (out_word)
    );

    assign m_tdata = {4'b0000, out_word.code};
    assign m_tlast = out_word.last;

endmodule

FILE: hw/rtl/cslbp_checker.sv
// ----------------------------------------------------------------------------
// CS-LBP port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module cslbp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    // A stalled word stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word withdrawn while stalled");

    // A stalled word keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // The padding above the code is always zero.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:4] == 4'b0000))
        else $error("output padding bits set");

    // Nothing is offered straight after reset, and no pixel is taken either,
    // since the line store is still being cleared.
    a_reset_quiet: assert property (@(posedge clk)
        $past(!rst_n) |-> !m_tvalid && !s_tready)
        else $error("activity directly after reset");

endmodule

bind center_symmetric_lbp_r2_8pt cslbp_checker u_checker (.*);

FILE: verif/tb_center_symmetric_lbp_r2_8pt.sv
// ----------------------------------------------------------------------------
// CS-LBP radius-2 eight-point stream testbench
// Feeds grayscale frames through the block under a range of row widths and
// frame heights, predicts every interior code and its frame mark, and checks
// each output word against that prediction while both sides idle at random.
// ----------------------------------------------------------------------------
module tb_center_symmetric_lbp_r2_8pt;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WIDTH = 1024;

    // A register index that the block does not decode; writes to it must be
    // ignored.
    localparam logic [cslbp_pkg::CFG_IDX_W-1:0] CFG_SPARE = 8'hFF;

    // Cycles a pixel may still be in flight after the last expected code has
    // come out, since border pixels produce no code.
    localparam int SETTLE_CYCLES = 16;

    // Generous ceiling for the whole run, including the line-store sweep.
    localparam int CYCLE_LIMIT = 1000000;

    localparam int RANDOM_ITEMS = 300;
    localparam int WIDE_ITEMS   = 64;

    // Styles of pixel content; flat and smooth content make ties likely.
    typedef enum int {
        PIX_UNIFORM,
        PIX_FLAT,
        PIX_SMOOTH
    } pixel_style_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    center_symmetric_lbp_r2_8pt #(
        .MAX_WIDTH (MAX_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor state: our own copy of the line store, the 5x5 window, the
    // raster position and the two registers, all at their reset values.
    // ------------------------------------------------------------------------
    logic [31:0]   line_mem [MAX_WIDTH];
    logic [39:0]   window [5];
    int unsigned   col_cnt    = 0;
    logic [15:0]   row_cnt    = '0;
    logic [10:0]   cfg_width  = 11'd640;
    logic [15:0]   cfg_height = 16'd480;

    logic [7:0]          pixel_queue [$];
    cslbp_pkg::result_t  code_queue [$];

    int unsigned   error_count = 0;
    int unsigned   cycle_count = 0;

    // Idling controls, changed by the stimulus between phases.
    int unsigned   gap_max    = 0;
    int unsigned   stall_pct  = 0;
    int unsigned   gap_left   = 0;
    int unsigned   burst_left = 0;
    int unsigned   stall_left = 0;
    pixel_style_t  pix_style  = PIX_UNIFORM;
    int            last_pix   = 128;

    initial
    begin
        foreach (line_mem[i])
            line_mem[i] = '0;
        foreach (window[i])
            window[i] = '0;
    end

    // Pixel of window row r, window column c; column 4 is the newest.
    function automatic int unsigned win_px(input int r, input int c);
        return 32'(window[c][8*r +: 8]);
    endfunction

    // Advances the predictor by one accepted pixel and queues the code it
    // produces, if its centre lies two or more pixels inside the frame.
    function automatic void predict_code(input logic [7:0] pix);
        int unsigned        eff_w;
        int unsigned        eff_h;
        int unsigned        col;
        int unsigned        row;
        int unsigned        ne;
        int unsigned        sw;
        int unsigned        nw;
        int unsigned        se;
        logic [31:0]        old;
        logic               end_row;
        logic               end_frame;
        cslbp_pkg::result_t res;

        eff_w = 32'(cfg_width);
        if (eff_w < 32'(cslbp_pkg::MIN_DIM))
            eff_w = 32'(cslbp_pkg::MIN_DIM);
        if (eff_w > MAX_WIDTH)
            eff_w = MAX_WIDTH;
        eff_h = 32'(cfg_height);
        if (eff_h < 32'(cslbp_pkg::MIN_DIM))
            eff_h = 32'(cslbp_pkg::MIN_DIM);

        col = col_cnt;
        if (col >= MAX_WIDTH)
            col = MAX_WIDTH - 1;
        row = 32'(row_cnt);

        // The stored column supplies rows r-4..r-1, the new pixel row r.
        old = line_mem[col];
        for (int j = 0; j < 4; j++)
            window[j] = window[j+1];
        window[4] = {pix, old};
        line_mem[col] = {pix, old[31:8]};

        end_row   = (col >= eff_w - 1);
        end_frame = end_row && (row >= eff_h - 1);

        if (row >= 32'(cslbp_pkg::MIN_EDGE) && col >= 32'(cslbp_pkg::MIN_EDGE))
        begin
            ne = cslbp_pkg::WGT_B * win_px(0, 3) + cslbp_pkg::WGT_A * win_px(0, 4)
               + cslbp_pkg::WGT_C * win_px(1, 3) + cslbp_pkg::WGT_B * win_px(1, 4);
            sw = cslbp_pkg::WGT_B * win_px(3, 0) + cslbp_pkg::WGT_C * win_px(3, 1)
               + cslbp_pkg::WGT_A * win_px(4, 0) + cslbp_pkg::WGT_B * win_px(4, 1);
            nw = cslbp_pkg::WGT_A * win_px(0, 0) + cslbp_pkg::WGT_B * win_px(0, 1)
               + cslbp_pkg::WGT_B * win_px(1, 0) + cslbp_pkg::WGT_C * win_px(1, 1);
            se = cslbp_pkg::WGT_C * win_px(3, 3) + cslbp_pkg::WGT_B * win_px(3, 4)
               + cslbp_pkg::WGT_B * win_px(4, 3) + cslbp_pkg::WGT_A * win_px(4, 4);
            // Ties set the bit: each sample is compared with >= its opposite.
            res.code[0] = (win_px(2, 4) >= win_px(2, 0));
            res.code[1] = (ne >= sw);
            res.code[2] = (win_px(0, 2) >= win_px(4, 2));
            res.code[3] = (nw >= se);
            res.last    = end_frame;
            code_queue.push_back(res);
        end

        if (end_row)
        begin
            col_cnt = 0;
            row_cnt = end_frame ? 16'd0 : row_cnt + 16'd1;
        end
        else
            col_cnt = col + 1;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------------
    // Pixel driver. Words leave the queue in bursts of random length with
    // random gaps between them; a word that is offered stays until taken.
    // The predictor advances at the edge where the word is accepted.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                predict_code(s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pixel_queue.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pixel_queue.pop_front();
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 32);
                        gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Code monitor. The sink stalls for runs of random length that start at
    // random; long runs fill the output buffer and hold the input back. Each
    // accepted word is checked against the oldest expected code.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cslbp_pkg::result_t want;

        if (rst_n)
        begin
            if (stall_left != 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(0, 11);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;

            if (m_tvalid && m_tready)
            begin
                if (code_queue.size() == 0)
                    report_mismatch($sformatf("unexpected word tdata=%h tlast=%b",
                                              m_tdata, m_tlast));
                else
                begin
                    want = code_queue.pop_front();
                    if (m_tdata[cslbp_pkg::CODE_W-1:0] !== want.code)
                        report_mismatch($sformatf("code %h, expected %h",
                                                  m_tdata[cslbp_pkg::CODE_W-1:0],
                                                  want.code));
                    if (m_tdata[7:cslbp_pkg::CODE_W] !== '0)
                        report_mismatch($sformatf("padding bits %h, expected zero",
                                                  m_tdata[7:cslbp_pkg::CODE_W]));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("tlast %b, expected %b",
                                                  m_tlast, want.last));
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Writes one register; the predictor's copy changes once the write is
    // taken. Unknown indexes leave both registers alone.
    task automatic write_reg(input logic [cslbp_pkg::CFG_IDX_W-1:0] reg_index,
                             input logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (reg_index == cslbp_pkg::CFG_LINE_WIDTH)
            cfg_width = value[10:0];
        else if (reg_index == cslbp_pkg::CFG_FRAME_HEIGHT)
            cfg_height = value;
    endtask

    // Waits until every queued pixel has been taken and every expected code
    // has come back, then lets the pipeline empty of border pixels.
    task automatic wait_idle();
        while (pixel_queue.size() != 0 || s_tvalid || code_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] next_pixel();
        case (pix_style)
            PIX_FLAT:
            begin
                case ($urandom_range(0, 4))
                    0: last_pix = 0;
                    1: last_pix = 1;
                    2: last_pix = 128;
                    3: last_pix = 254;
                    default: last_pix = 255;
                endcase
            end
            PIX_SMOOTH:
            begin
                last_pix = last_pix + $urandom_range(0, 4) - 2;
                if (last_pix < 0)
                    last_pix = 0;
                if (last_pix > 255)
                    last_pix = 255;
            end
            default:
                last_pix = $urandom_range(0, 255);
        endcase
        return last_pix[7:0];
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus. The registers change only between phases, with the block
    // idle; the raster position carries over, so a phase often starts part
    // of the way through a row or a frame.
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned random_items;
        int unsigned phase_len;
        int unsigned sel;
        logic [10:0] width_raw;
        logic [15:0] height_raw;
        logic [7:0]  directed_px [3];

        random_items = 0;
        directed_px[0] = 8'h00;
        directed_px[1] = 8'hFF;
        directed_px[2] = 8'h80;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Smallest frame, reached through widths and heights below the
        // minimum, plus a write to an index the block does not decode. One
        // 5x5 frame of extreme values gives one code with tlast.
        write_reg(cslbp_pkg::CFG_LINE_WIDTH, 16'd3);
        write_reg(cslbp_pkg::CFG_FRAME_HEIGHT, 16'd2);
        write_reg(CFG_SPARE, 16'hFFFF);
        for (int r = 0; r < 5; r++)
            for (int c = 0; c < 5; c++)
                pixel_queue.push_back(directed_px[(r + 2 * c) % 3]);
        wait_idle();

        // Widest rows: the largest width value clamps to MAX_WIDTH, so a run
        // of pixels well past the narrow widths must not end the row.
        write_reg(cslbp_pkg::CFG_LINE_WIDTH, 16'hFFFF);
        write_reg(cslbp_pkg::CFG_FRAME_HEIGHT, cslbp_pkg::MIN_DIM);
        gap_max   = 3;
        stall_pct = 10;
        for (int i = 0; i < WIDE_ITEMS; i++)
            pixel_queue.push_back(next_pixel());
        wait_idle();

        // Random phases: mostly narrow frames so that codes are frequent,
        // with heights under the minimum, heights too large to finish, and
        // now and then a row width beyond the clamp.
        while (random_items < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 19);
            if (sel < 14)
                width_raw = 11'($urandom_range(5, 24));
            else if (sel < 17)
                width_raw = 11'($urandom_range(0, 4));
            else if (sel < 19)
                width_raw = 11'($urandom_range(25, 64));
            else
                width_raw = 11'($urandom_range(1025, 2047));

            sel = $urandom_range(0, 19);
            if (sel < 13)
                height_raw = 16'($urandom_range(5, 12));
            else if (sel < 16)
                height_raw = 16'($urandom_range(0, 4));
            else if (sel < 18)
                height_raw = 16'hFFFF;
            else
                height_raw = 16'($urandom_range(13, 65534));

            // Spare upper data bits ride along with the width and must be
            // dropped by the register.
            write_reg(cslbp_pkg::CFG_LINE_WIDTH, {5'($urandom_range(0, 31)), width_raw});
            write_reg(cslbp_pkg::CFG_FRAME_HEIGHT, height_raw);
            if ($urandom_range(0, 7) == 0)
                write_reg(cslbp_pkg::CFG_IDX_W'($urandom_range(2, 255)), 16'($urandom));

            case ($urandom_range(0, 2))
                0: gap_max = 0;
                1: gap_max = 2;
                default: gap_max = 8;
            endcase
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 20;
                default: stall_pct = 60;
            endcase
            pix_style = pixel_style_t'($urandom_range(0, 2));

            phase_len = (32'(width_raw) > MAX_WIDTH) ? $urandom_range(10, 60)
                                                     : $urandom_range(20, 120);
            repeat (phase_len)
                pixel_queue.push_back(next_pixel());
            random_items += phase_len;
            wait_idle();
        end

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
